@@ hw/rtl/gbs_pkg.sv @@
// shared types and constants of the gf2 ring basis selector
`timescale 1ns / 1ps

package gbs_pkg;

  // fixed field widths of the channels and the register
  localparam int unsigned RING_W     = 64;
  localparam int unsigned WEIGHT_W   = 7;
  localparam int unsigned SIZE_W     = 6;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned CHUNK_W    = 8;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // reset value of min_new_edges
  localparam logic [CFG_W-1:0] MIN_EDGES_RST = 7'd3;

  // register index as seen in paddr[2]
  localparam logic REG_MIN_NEW_EDGES = 1'b0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              load_cand;
    logic              rd_en;
    logic              reduce;
    logic              mem_we;
    logic              wsel_row;
    logic              wt_clr;
    logic              wt_acc;
    logic              load_out;
    logic              out_acc;
    logic              out_full;
    logic [SIZE_W-1:0] out_size;
  } gbs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic row_above;
    logic wt_last;
    logic qualify;
  } gbs_sts_t;

endpackage

@@ hw/rtl/gbs_in_if.sv @@
// candidate channel: ring edge mask and start flag
`timescale 1ns / 1ps

interface gbs_in_if import gbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RING_W-1:0] ring_edges;
  logic              start_new;

  modport source (output valid, ring_edges, start_new, input ready);
  modport sink (input valid, ring_edges, start_new, output ready);
endinterface

@@ hw/rtl/gbs_out_if.sv @@
// result channel: acceptance, residual weight and basis status
`timescale 1ns / 1ps

interface gbs_out_if import gbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                accepted;
  logic [WEIGHT_W-1:0] residual_weight;
  logic [SIZE_W-1:0]   basis_size;
  logic                basis_full;

  modport source (output valid, accepted, residual_weight, basis_size, basis_full,
                  input ready);
  modport sink (input valid, accepted, residual_weight, basis_size, basis_full,
                output ready);
endinterface

@@ hw/rtl/gbs_datapath.sv @@
// datapath: basis row memory, candidate register, weight counter, result register
`timescale 1ns / 1ps

module gbs_datapath import gbs_pkg::*; #(
  parameter int unsigned EDGE_BITS = 64,
  parameter int unsigned MAX_ROWS  = 32,
  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbs_cmd_t            cmd_i,
  input  logic [AW-1:0]       raddr_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [RING_W-1:0]   ring_edges_i,
  input  logic [CFG_W-1:0]    min_new_edges_i,
  output gbs_sts_t            sts_o,
  output logic                accepted_o,
  output logic [WEIGHT_W-1:0] residual_weight_o,
  output logic [SIZE_W-1:0]   basis_size_o,
  output logic                basis_full_o
);

  localparam int unsigned NCH = (EDGE_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned CHW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned PADW = NCH * CHUNK_W;

  logic [EDGE_BITS-1:0] mem_q [MAX_ROWS];
  logic [EDGE_BITS-1:0] rdata_q;
  logic [EDGE_BITS-1:0] cand_q;
  logic [EDGE_BITS-1:0] wdata;
  logic [EDGE_BITS:0]   row_key;
  logic [EDGE_BITS:0]   cand_key;
  logic                 reduce_hit;
  logic [PADW-1:0]      cand_pad;
  logic [CHUNK_W-1:0]   chunk;
  logic [WEIGHT_W-1:0]  wt_q;
  logic [CHW-1:0]       ch_q;
  logic                 acc_q;
  logic                 full_q;
  logic [SIZE_W-1:0]    size_q;
  logic [WEIGHT_W-1:0]  wt_out_q;

  // sort key: isolated lowest set bit, zero rows sort after every other row
  function automatic logic [EDGE_BITS:0] pivot_key(input logic [EDGE_BITS-1:0] v);
    logic [EDGE_BITS-1:0] neg;
    neg = EDGE_BITS'(~v + 1'b1);
    return {(v == '0), v & neg};
  endfunction

  // ones in one byte
  function automatic logic [3:0] ones8(input logic [CHUNK_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

  // row memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[waddr_i] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign wdata      = cmd_i.wsel_row ? rdata_q : cand_q;
  assign row_key    = pivot_key(rdata_q);
  assign cand_key   = pivot_key(cand_q);
  assign reduce_hit = |(cand_q & row_key[EDGE_BITS-1:0]);

  // candidate load and elimination step
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cand) begin
      cand_q <= ring_edges_i[EDGE_BITS-1:0];
    end else if (cmd_i.reduce && reduce_hit) begin
      cand_q <= cand_q ^ rdata_q;
    end
  end

  // weight count, one byte per cycle
  assign cand_pad = PADW'(cand_q);
  assign chunk    = cand_pad[ch_q*CHUNK_W +: CHUNK_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q <= '0;
      ch_q <= '0;
    end else if (cmd_i.wt_clr) begin
      wt_q <= '0;
      ch_q <= '0;
    end else if (cmd_i.wt_acc) begin
      wt_q <= wt_q + WEIGHT_W'(ones8(chunk));
      ch_q <= ch_q + CHW'(1);
    end
  end

  // status back to the controller
  assign sts_o.row_above = row_key > cand_key;
  assign sts_o.wt_last   = ch_q == CHW'(NCH - 1);
  assign sts_o.qualify   = wt_q >= min_new_edges_i;

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      acc_q    <= cmd_i.out_acc;
      full_q   <= cmd_i.out_full;
      size_q   <= cmd_i.out_size;
      wt_out_q <= wt_q;
    end
  end

  assign accepted_o        = acc_q;
  assign residual_weight_o = wt_out_q;
  assign basis_size_o      = size_q;
  assign basis_full_o      = full_q;

endmodule

@@ hw/rtl/gbs_ctrl.sv @@
// controller: sequences elimination, weight count, decision and sorted insertion
`timescale 1ns / 1ps

module gbs_ctrl import gbs_pkg::*; #(
  parameter int unsigned MAX_ROWS = 32,
  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned CW = $clog2(MAX_ROWS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_start_new_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  gbs_sts_t      sts_i,
  output gbs_cmd_t      cmd_o,
  output logic [AW-1:0] raddr_o,
  output logic [AW-1:0] waddr_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STORE0 = 3'd1;
  localparam logic [2:0] S_ELIM   = 3'd2;
  localparam logic [2:0] S_WEIGHT = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_INSERT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rvld_q, rvld_d;
  logic [AW-1:0] raddr_q, raddr_d;
  logic          empty_q, empty_d;
  logic          acc_q, acc_d;
  logic          full_q, full_d;
  logic          out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rvld_d      = rvld_q;
    raddr_d     = raddr_q;
    empty_d     = empty_q;
    acc_d       = acc_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o          = '0;
    cmd_o.out_acc  = acc_q;
    cmd_o.out_full = full_q;
    cmd_o.out_size = SIZE_W'(count_q);
    raddr_o        = idx_q[AW-1:0];
    waddr_o        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_cand = 1'b1;
          cmd_o.wt_clr    = 1'b1;
          acc_d   = 1'b0;
          full_d  = 1'b0;
          empty_d = 1'b0;
          idx_d   = '0;
          rvld_d  = 1'b0;
          if (in_start_new_i || count_q == '0) begin
            count_d = '0;
            state_d = S_STORE0;
          end else begin
            state_d = S_ELIM;
          end
        end
      end
      // empty basis or start_new candidate: candidate goes to row 0 as is
      S_STORE0: begin
        cmd_o.mem_we = 1'b1;
        waddr_o      = '0;
        count_d      = CW'(1);
        empty_d      = 1'b1;
        state_d      = S_WEIGHT;
      end
      // stream rows 0 .. count-1 through the reduction step
      S_ELIM: begin
        cmd_o.rd_en  = idx_q < count_q;
        cmd_o.reduce = rvld_q;
        rvld_d       = cmd_o.rd_en;
        if (cmd_o.rd_en) begin
          idx_d = idx_q + CW'(1);
        end
        if (!cmd_o.rd_en && !rvld_q) begin
          state_d = S_WEIGHT;
        end
      end
      S_WEIGHT: begin
        cmd_o.wt_acc = 1'b1;
        if (sts_i.wt_last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (empty_q) begin
          acc_d   = 1'b1;
          state_d = S_DONE;
        end else if (sts_i.qualify) begin
          if (count_q >= CW'(MAX_ROWS)) begin
            full_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            idx_d   = count_q;
            rvld_d  = 1'b0;
            state_d = S_INSERT;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      // scan from the top, move rows with a higher pivot up by one
      S_INSERT: begin
        if (rvld_q && !sts_i.row_above) begin
          cmd_o.mem_we = 1'b1;
          waddr_o      = raddr_q + AW'(1);
          count_d      = count_q + CW'(1);
          acc_d        = 1'b1;
          rvld_d       = 1'b0;
          state_d      = S_DONE;
        end else if (!rvld_q && idx_q == '0) begin
          cmd_o.mem_we = 1'b1;
          waddr_o      = '0;
          count_d      = count_q + CW'(1);
          acc_d        = 1'b1;
          state_d      = S_DONE;
        end else begin
          if (rvld_q) begin
            cmd_o.mem_we   = 1'b1;
            cmd_o.wsel_row = 1'b1;
            waddr_o        = raddr_q + AW'(1);
          end
          if (idx_q != '0) begin
            cmd_o.rd_en = 1'b1;
            raddr_o     = AW'(idx_q - CW'(1));
            raddr_d     = AW'(idx_q - CW'(1));
            idx_d       = idx_q - CW'(1);
            rvld_d      = 1'b1;
          end else begin
            rvld_d = 1'b0;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rvld_q      <= 1'b0;
      raddr_q     <= '0;
      empty_q     <= 1'b0;
      acc_q       <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rvld_q      <= rvld_d;
      raddr_q     <= raddr_d;
      empty_q     <= empty_d;
      acc_q       <= acc_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  // row count stays within the memory
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ROWS))
    else $error("row count above capacity");

  // only stored rows are read
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (CW'(raddr_o) < count_q))
    else $error("read of a row beyond the row count");

  // writes land at or below the count and only while there is room
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_we |-> (CW'(waddr_o) <= count_q) && (count_q < CW'(MAX_ROWS)))
    else $error("row write outside the free range");

  // a result never reports both a stored row and a full basis
  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(acc_q && full_q))
    else $error("accepted and full set together");

endmodule

@@ hw/rtl/gf2_ring_basis_selector.sv @@
// top level: candidate and result channels, configuration port, controller and datapath
`timescale 1ns / 1ps

// Incremental GF(2) elimination of ring candidates against a basis of up to
// MAX_ROWS rows kept sorted by lowest set bit, in a single-port-read row memory.
// One candidate is processed at a time. A candidate passes through elimination
// against the stored rows (one memory read per row), a weight count (one byte
// per cycle), a decision and, when it is stored, insertion, in which the rows
// with a higher pivot are shifted up (one row move per cycle); it is taken in
// the idle state and its result is handed over from the done state. An empty
// basis or a start_new candidate goes to row 0 as is and skips elimination and
// insertion. A finished result waits in an output register, so the next
// candidate can be taken while the previous result is still pending. The row
// memory has no reset and needs no clearing pass; only rows below the row count
// are ever read.
module gf2_ring_basis_selector import gbs_pkg::*; #(
  parameter int unsigned EDGE_BITS = 64,
  parameter int unsigned MAX_ROWS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gbs_in_if.sink                cand_i,
  gbs_out_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [CFG_W-1:0] min_edges_q;
  logic             cfg_wr;
  gbs_cmd_t         cmd;
  gbs_sts_t         sts;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MIN_NEW_EDGES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_edges_q <= MIN_EDGES_RST;
    end else if (cfg_wr) begin
      min_edges_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MIN_NEW_EDGES) ? APB_DATA_W'(min_edges_q) : '0;

  // controller
  gbs_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (cand_i.valid),
    .in_start_new_i (cand_i.start_new),
    .in_ready_o     (cand_i.ready),
    .out_valid_o    (res_o.valid),
    .out_ready_i    (res_o.ready),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .raddr_o        (raddr),
    .waddr_o        (waddr)
  );

  // datapath
  gbs_datapath #(
    .EDGE_BITS (EDGE_BITS),
    .MAX_ROWS  (MAX_ROWS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .raddr_i           (raddr),
    .waddr_i           (waddr),
    .ring_edges_i      (cand_i.ring_edges),
    .min_new_edges_i   (min_edges_q),
    .sts_o             (sts),
    .accepted_o        (res_o.accepted),
    .residual_weight_o (res_o.residual_weight),
    .basis_size_o      (res_o.basis_size),
    .basis_full_o      (res_o.basis_full)
  );

endmodule
